### sv/cfadj_pkg.sv
// calendar field adjust package: codes, state types and calendar helpers
// used by the interfaces, the register block, the step logic and the top level
// no dependencies
package cfadj_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int FOCUS_W  = 3;
    localparam int FUNC_W   = 2;

    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 14'd9999;
    localparam logic [YEAR_W-1:0]   YEAR_RESET   = 14'd2004;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_FIRST    = 5'd1;
    localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;

    // modular inverse of 25 mod 2^14 and the divisibility bound (2^14-1)/25
    localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

    // apb register map
    localparam int                PADDR_W      = 3;
    localparam logic [0:0]        REG_MIN_YEAR = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_UP    = 2'd1,
        FUNC_DOWN  = 2'd2,
        FUNC_FOCUS = 2'd3
    } t_func;

    typedef enum logic [FOCUS_W-1:0] {
        FOCUS_HOUR   = 3'd0,
        FOCUS_MINUTE = 3'd1,
        FOCUS_YEAR   = 3'd2,
        FOCUS_MONTH  = 3'd3,
        FOCUS_DAY    = 3'd4
    } t_focus;

    typedef struct packed {
        t_func                func;
        logic [FOCUS_W-1:0]   focus_select;
        logic [YEAR_W-1:0]    load_year;
        logic [MONTH_W-1:0]   load_month;
        logic [DAY_W-1:0]     load_day;
        logic [HOUR_W-1:0]    load_hour;
        logic [MINUTE_W-1:0]  load_minute;
    } t_item;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        t_focus               focus;
    } t_cal;

    localparam t_cal CAL_RESET = '{
        year:   YEAR_RESET,
        month:  MONTH_FIRST,
        day:    DAY_FIRST,
        hour:   '0,
        minute: '0,
        focus:  FOCUS_HOUR
    };

    // gregorian rule: 400 = 16*25, 100 = 4*25
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] p;
        logic              div25;
        p     = y * INV25;
        div25 = (p <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### sv/cfadj_if.sv
// request and result channel interfaces of the calendar field adjust unit
// depends on cfadj_pkg for the field widths
interface cfadj_in_if;
    logic                              valid;
    logic                              ready;
    logic [cfadj_pkg::FUNC_W-1:0]      func;
    logic [cfadj_pkg::FOCUS_W-1:0]     focus_select;
    logic [cfadj_pkg::YEAR_W-1:0]      load_year;
    logic [cfadj_pkg::MONTH_W-1:0]     load_month;
    logic [cfadj_pkg::DAY_W-1:0]       load_day;
    logic [cfadj_pkg::HOUR_W-1:0]      load_hour;
    logic [cfadj_pkg::MINUTE_W-1:0]    load_minute;

    modport source (
        output valid, func, focus_select, load_year, load_month, load_day,
               load_hour, load_minute,
        input  ready
    );
    modport sink (
        input  valid, func, focus_select, load_year, load_month, load_day,
               load_hour, load_minute,
        output ready
    );
endinterface

interface cfadj_out_if;
    logic                              valid;
    logic                              ready;
    logic [cfadj_pkg::YEAR_W-1:0]      year_out;
    logic [cfadj_pkg::MONTH_W-1:0]     month_out;
    logic [cfadj_pkg::DAY_W-1:0]       day_out;
    logic [cfadj_pkg::HOUR_W-1:0]      hour_out;
    logic [cfadj_pkg::MINUTE_W-1:0]    minute_out;
    logic [cfadj_pkg::FOCUS_W-1:0]     focus_out;

    modport source (
        output valid, year_out, month_out, day_out, hour_out, minute_out,
               focus_out,
        input  ready
    );
    modport sink (
        input  valid, year_out, month_out, day_out, hour_out, minute_out,
               focus_out,
        output ready
    );
endinterface

### sv/cfadj_regs.sv
// apb register block of the calendar field adjust unit: holds min_year
// depends on cfadj_pkg
module cfadj_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [cfadj_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [31:0]                      i_pwdata,
    output logic [31:0]                      o_prdata,
    output logic                             o_pready,
    output logic [cfadj_pkg::YEAR_W-1:0]     o_min_year
);
    logic                           w_hit;
    logic                           w_wr;
    logic [cfadj_pkg::YEAR_W-1:0]   r_min_year;
    logic [cfadj_pkg::YEAR_W-1:0]   n_min_year;

    assign w_hit = (i_paddr[2] == cfadj_pkg::REG_MIN_YEAR);
    assign w_wr  = i_psel && i_penable && i_pwrite && w_hit;

    always_comb begin
        n_min_year = r_min_year;
        if (w_wr) begin
            n_min_year = i_pwdata[cfadj_pkg::YEAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= cfadj_pkg::YEAR_RESET;
        end else begin
            r_min_year <= n_min_year;
        end
    end

    assign o_prdata   = w_hit ? {{(32-cfadj_pkg::YEAR_W){1'b0}}, r_min_year} : 32'd0;
    assign o_pready   = 1'b1;
    assign o_min_year = r_min_year;
endmodule

### sv/cfadj_step.sv
// next-state logic of the calendar field adjust unit: applies one request
// to the stored date, time and focus; depends on cfadj_pkg
module cfadj_step (
    input  cfadj_pkg::t_item                 i_item,
    input  cfadj_pkg::t_cal                  i_cur,
    input  logic [cfadj_pkg::YEAR_W-1:0]     i_min_year,
    output cfadj_pkg::t_cal                  o_next
);
    logic                           w_up;
    logic                           w_step;
    logic [cfadj_pkg::YEAR_W-1:0]   w_floor;
    logic [cfadj_pkg::YEAR_W-1:0]   w_year_dn;
    logic [cfadj_pkg::YEAR_W-1:0]   w_year;
    logic [cfadj_pkg::MONTH_W-1:0]  w_month;
    logic [cfadj_pkg::DAY_W-1:0]    w_day_base;
    logic [cfadj_pkg::DAY_W-1:0]    w_len;
    logic                           w_day_step;

    assign w_up   = (i_item.func == cfadj_pkg::FUNC_UP);
    assign w_step = (i_item.func == cfadj_pkg::FUNC_UP) ||
                    (i_item.func == cfadj_pkg::FUNC_DOWN);
    assign w_floor   = (i_min_year > cfadj_pkg::YEAR_MAX) ? cfadj_pkg::YEAR_MAX : i_min_year;
    // year never wraps below zero, then takes the floor
    assign w_year_dn = (i_cur.year > '0) ? i_cur.year - 1'b1 : '0;

    // year and month first, the day length follows from them
    always_comb begin
        w_year  = i_cur.year;
        w_month = i_cur.month;
        if (i_item.func == cfadj_pkg::FUNC_LOAD) begin
            w_year  = (i_item.load_year > cfadj_pkg::YEAR_MAX) ?
                      cfadj_pkg::YEAR_MAX : i_item.load_year;
            w_month = (i_item.load_month < cfadj_pkg::MONTH_FIRST) ? cfadj_pkg::MONTH_FIRST :
                      (i_item.load_month > cfadj_pkg::MONTH_LAST) ? cfadj_pkg::MONTH_LAST :
                      i_item.load_month;
        end else if (w_step && i_cur.focus == cfadj_pkg::FOCUS_YEAR) begin
            if (w_up) begin
                w_year = (i_cur.year < cfadj_pkg::YEAR_MAX) ? i_cur.year + 1'b1 : i_cur.year;
            end else begin
                w_year = (w_year_dn < w_floor) ? w_floor : w_year_dn;
            end
        end else if (w_step && i_cur.focus == cfadj_pkg::FOCUS_MONTH) begin
            if (w_up) begin
                w_month = (i_cur.month < cfadj_pkg::MONTH_LAST) ?
                          i_cur.month + 1'b1 : cfadj_pkg::MONTH_FIRST;
            end else begin
                w_month = (i_cur.month > cfadj_pkg::MONTH_FIRST) ?
                          i_cur.month - 1'b1 : cfadj_pkg::MONTH_LAST;
            end
        end
    end

    assign w_len      = cfadj_pkg::month_len(w_month, w_year);
    assign w_day_step = w_step && (i_cur.focus == cfadj_pkg::FOCUS_DAY);
    assign w_day_base = (i_item.func != cfadj_pkg::FUNC_LOAD) ? i_cur.day :
                        (i_item.load_day < cfadj_pkg::DAY_FIRST) ? cfadj_pkg::DAY_FIRST :
                        i_item.load_day;

    always_comb begin
        o_next       = i_cur;
        o_next.year  = w_year;
        o_next.month = w_month;
        if (w_day_step) begin
            if (w_up) begin
                o_next.day = (i_cur.day < w_len) ? i_cur.day + 1'b1 : cfadj_pkg::DAY_FIRST;
            end else begin
                o_next.day = (i_cur.day > cfadj_pkg::DAY_FIRST) ? i_cur.day - 1'b1 : w_len;
            end
        end else begin
            o_next.day = (w_day_base > w_len) ? w_len : w_day_base;
        end

        case (i_item.func)
            cfadj_pkg::FUNC_LOAD: begin
                o_next.hour   = (i_item.load_hour > cfadj_pkg::HOUR_LAST) ?
                                cfadj_pkg::HOUR_LAST : i_item.load_hour;
                o_next.minute = (i_item.load_minute > cfadj_pkg::MINUTE_LAST) ?
                                cfadj_pkg::MINUTE_LAST : i_item.load_minute;
            end
            cfadj_pkg::FUNC_UP, cfadj_pkg::FUNC_DOWN: begin
                if (i_cur.focus == cfadj_pkg::FOCUS_HOUR) begin
                    if (w_up) begin
                        o_next.hour = (i_cur.hour < cfadj_pkg::HOUR_LAST) ?
                                      i_cur.hour + 1'b1 : '0;
                    end else begin
                        o_next.hour = (i_cur.hour > '0) ?
                                      i_cur.hour - 1'b1 : cfadj_pkg::HOUR_LAST;
                    end
                end else if (i_cur.focus == cfadj_pkg::FOCUS_MINUTE) begin
                    if (w_up) begin
                        o_next.minute = (i_cur.minute < cfadj_pkg::MINUTE_LAST) ?
                                        i_cur.minute + 1'b1 : '0;
                    end else begin
                        o_next.minute = (i_cur.minute > '0) ?
                                        i_cur.minute - 1'b1 : cfadj_pkg::MINUTE_LAST;
                    end
                end
            end
            default: begin
                // out-of-range select keeps the focus
                if (i_item.focus_select <= cfadj_pkg::FOCUS_DAY) begin
                    o_next.focus = cfadj_pkg::t_focus'(i_item.focus_select);
                end
            end
        endcase
    end
endmodule

### sv/calendar_field_up_down_adjust_unit.sv
// calendar field adjust unit top level: request register, calendar state,
// result register; depends on cfadj_pkg, cfadj_if, cfadj_regs and cfadj_step
//
// Holds a date and time (year, month, day, hour, minute) and a focused field.
// Each request loads the whole date and time, steps the focused field up or
// down, or selects a new focus; each request returns one result with all
// fields and the focus after it. One request is taken every clock cycle while
// results drain; an accepted request waits in the request register until the
// result register is free or drains, then the step logic feeds the state and
// result registers. The longest path is the leap-year test, one 14-bit constant
// multiply after the year update. min_year (byte address 0) is the floor for
// a year step down and must be written only while no request is in flight.
module calendar_field_up_down_adjust_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cfadj_in_if.sink                         i_in,
    cfadj_out_if.source                      o_out,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [cfadj_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [31:0]                      i_pwdata,
    output logic [31:0]                      o_prdata,
    output logic                             o_pready
);
    logic                           w_in_ready;
    logic                           w_in_take;
    logic                           w_adv;
    logic [cfadj_pkg::YEAR_W-1:0]   w_min_year;
    cfadj_pkg::t_item               w_item;
    cfadj_pkg::t_cal                w_next;

    logic                           r_in_valid;
    logic                           n_in_valid;
    cfadj_pkg::t_item               r_in;
    cfadj_pkg::t_cal                r_cal;
    logic                           r_out_valid;
    logic                           n_out_valid;
    cfadj_pkg::t_cal                r_out;

    cfadj_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .o_min_year (w_min_year)
    );

    cfadj_step u_step (
        .i_item     (r_in),
        .i_cur      (r_cal),
        .i_min_year (w_min_year),
        .o_next     (w_next)
    );

    assign w_item = '{
        func:         cfadj_pkg::t_func'(i_in.func),
        focus_select: i_in.focus_select,
        load_year:    i_in.load_year,
        load_month:   i_in.load_month,
        load_day:     i_in.load_day,
        load_hour:    i_in.load_hour,
        load_minute:  i_in.load_minute
    };

    // the request moves on whenever the result register is free or drains
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign w_in_take  = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cal       <= cfadj_pkg::CAL_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_adv) begin
                r_cal <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= w_item;
        end
        if (w_adv) begin
            r_out <= w_next;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.year_out   = r_out.year;
    assign o_out.month_out  = r_out.month;
    assign o_out.day_out    = r_out.day;
    assign o_out.hour_out   = r_out.hour;
    assign o_out.minute_out = r_out.minute;
    assign o_out.focus_out  = r_out.focus;

`ifndef SYNTH
    // stored day always fits the stored month
    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal.day >= cfadj_pkg::DAY_FIRST) &&
        (r_cal.day <= cfadj_pkg::month_len(r_cal.month, r_cal.year)))
        else $error("stored day outside month length");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal.year <= cfadj_pkg::YEAR_MAX) && (r_cal.month >= cfadj_pkg::MONTH_FIRST) &&
        (r_cal.month <= cfadj_pkg::MONTH_LAST) && (r_cal.hour <= cfadj_pkg::HOUR_LAST) &&
        (r_cal.minute <= cfadj_pkg::MINUTE_LAST))
        else $error("stored calendar field out of range");

    // a stalled request stays in the request register
    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("stalled request lost");

    // each result leaves with the state it produced
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid && (r_out == r_cal))
        else $error("result register differs from state");
`endif
endmodule

### sim/testbench.sv
// self-checking testbench for calendar_field_up_down_adjust_unit: directed and random
// requests, with sender gaps and receiver stalls, and min_year writes over the apb port
// depends on cfadj_pkg, cfadj_if and the rtl of the unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_LIMIT = 10;

    typedef logic [cfadj_pkg::YEAR_W-1:0]   t_year;
    typedef logic [cfadj_pkg::MONTH_W-1:0]  t_month;
    typedef logic [cfadj_pkg::DAY_W-1:0]    t_day;
    typedef logic [cfadj_pkg::HOUR_W-1:0]   t_hour;
    typedef logic [cfadj_pkg::MINUTE_W-1:0] t_minute;
    typedef logic [cfadj_pkg::FOCUS_W-1:0]  t_sel;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [cfadj_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cfadj_in_if  req_if ();
    cfadj_out_if res_if ();

    calendar_field_up_down_adjust_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (req_if),
        .o_out     (res_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    cfadj_pkg::t_cal   shadow_cal;
    t_year             min_year_shadow;
    cfadj_pkg::t_cal   expected_cal[$];
    int                errors;
    int                cycles;
    int                sender_idle_pct;
    int                receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int days_in_month(input int m, input int y);
        bit leap;
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        if (m == 2)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic cfadj_pkg::t_cal advance_calendar(input cfadj_pkg::t_cal c,
                                                         input cfadj_pkg::t_item it,
                                                         input t_year min_year);
        int y, mo, d, h, mi, floor_year;
        bit up;
        y  = c.year;
        mo = c.month;
        d  = c.day;
        h  = c.hour;
        mi = c.minute;
        up = (it.func == cfadj_pkg::FUNC_UP);
        floor_year = (min_year > 9999) ? 9999 : min_year;
        case (it.func)
            cfadj_pkg::FUNC_LOAD: begin
                y  = (it.load_year > 9999) ? 9999 : it.load_year;
                mo = (it.load_month < 1) ? 1 : ((it.load_month > 12) ? 12 : it.load_month);
                d  = (it.load_day < 1) ? 1 : it.load_day;
                if (d > days_in_month(mo, y))
                    d = days_in_month(mo, y);
                h  = (it.load_hour > 23) ? 23 : it.load_hour;
                mi = (it.load_minute > 59) ? 59 : it.load_minute;
            end
            cfadj_pkg::FUNC_UP, cfadj_pkg::FUNC_DOWN: begin
                case (c.focus)
                    cfadj_pkg::FOCUS_HOUR: begin
                        if (up) h = (h < 23) ? h + 1 : 0;
                        else    h = (h > 0) ? h - 1 : 23;
                    end
                    cfadj_pkg::FOCUS_MINUTE: begin
                        if (up) mi = (mi < 59) ? mi + 1 : 0;
                        else    mi = (mi > 0) ? mi - 1 : 59;
                    end
                    cfadj_pkg::FOCUS_YEAR: begin
                        if (up) begin
                            if (y < 9999) y = y + 1;
                        end else begin
                            if (y > 0) y = y - 1;
                            if (y < floor_year) y = floor_year;
                        end
                        if (d > days_in_month(mo, y))
                            d = days_in_month(mo, y);
                    end
                    cfadj_pkg::FOCUS_MONTH: begin
                        if (up) mo = (mo < 12) ? mo + 1 : 1;
                        else    mo = (mo > 1) ? mo - 1 : 12;
                        if (d > days_in_month(mo, y))
                            d = days_in_month(mo, y);
                    end
                    cfadj_pkg::FOCUS_DAY: begin
                        if (up) d = (d < days_in_month(mo, y)) ? d + 1 : 1;
                        else    d = (d > 1) ? d - 1 : days_in_month(mo, y);
                    end
                    default: ;
                endcase
            end
            default: begin
                // out of range selections keep the current focus
                if (it.focus_select <= cfadj_pkg::FOCUS_DAY)
                    c.focus = cfadj_pkg::t_focus'(it.focus_select);
            end
        endcase
        c.year   = t_year'(y);
        c.month  = t_month'(mo);
        c.day    = t_day'(d);
        c.hour   = t_hour'(h);
        c.minute = t_minute'(mi);
        return c;
    endfunction

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin : check_results
        cfadj_pkg::t_cal want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_cal.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: %0d-%0d-%0d %0d:%0d focus %0d",
                             res_if.year_out, res_if.month_out, res_if.day_out,
                             res_if.hour_out, res_if.minute_out, res_if.focus_out);
            end else begin
                want = expected_cal.pop_front();
                if (res_if.year_out !== want.year || res_if.month_out !== want.month ||
                    res_if.day_out !== want.day || res_if.hour_out !== want.hour ||
                    res_if.minute_out !== want.minute || res_if.focus_out !== want.focus)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"mismatch: expected %0d-%0d-%0d %0d:%0d focus %0d,",
                                  " got %0d-%0d-%0d %0d:%0d focus %0d"},
                                 want.year, want.month, want.day, want.hour, want.minute,
                                 want.focus, res_if.year_out, res_if.month_out,
                                 res_if.day_out, res_if.hour_out, res_if.minute_out,
                                 res_if.focus_out);
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic push_request(input cfadj_pkg::t_item it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= it.func;
        req_if.focus_select <= it.focus_select;
        req_if.load_year    <= it.load_year;
        req_if.load_month   <= it.load_month;
        req_if.load_day     <= it.load_day;
        req_if.load_hour    <= it.load_hour;
        req_if.load_minute  <= it.load_minute;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        shadow_cal = advance_calendar(shadow_cal, it, min_year_shadow);
        expected_cal.push_back(shadow_cal);
    endtask

    task automatic send_load(input int y, input int m, input int d, input int h,
                             input int mi);
        cfadj_pkg::t_item it;
        it.func         = cfadj_pkg::FUNC_LOAD;
        it.focus_select = t_sel'($urandom);
        it.load_year    = t_year'(y);
        it.load_month   = t_month'(m);
        it.load_day     = t_day'(d);
        it.load_hour    = t_hour'(h);
        it.load_minute  = t_minute'(mi);
        push_request(it);
    endtask

    task automatic send_op(input cfadj_pkg::t_func f, input int sel);
        cfadj_pkg::t_item it;
        it.func         = f;
        it.focus_select = t_sel'(sel);
        it.load_year    = t_year'($urandom);
        it.load_month   = t_month'($urandom);
        it.load_day     = t_day'($urandom);
        it.load_hour    = t_hour'($urandom);
        it.load_minute  = t_minute'($urandom);
        push_request(it);
    endtask

    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        while (expected_cal.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min_year(input t_year value);
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {cfadj_pkg::REG_MIN_YEAR, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_year_shadow = value;
    endtask

    function automatic cfadj_pkg::t_item random_request();
        cfadj_pkg::t_item it;
        int    pick, floor_year;
        pick = $urandom_range(0, 99);
        if (pick < 20)      it.func = cfadj_pkg::FUNC_LOAD;
        else if (pick < 50) it.func = cfadj_pkg::FUNC_UP;
        else if (pick < 80) it.func = cfadj_pkg::FUNC_DOWN;
        else                it.func = cfadj_pkg::FUNC_FOCUS;
        it.focus_select = ($urandom_range(0, 9) == 0) ? t_sel'($urandom_range(5, 7))
                                                      : t_sel'($urandom_range(0, 4));
        floor_year = (min_year_shadow > 9999) ? 9999 : min_year_shadow;
        case ($urandom_range(0, 7))
            0: it.load_year = t_year'($urandom);
            1: it.load_year = t_year'($urandom_range(9995, 9999));
            2: it.load_year = t_year'($urandom_range(0, 4));
            3: it.load_year = t_year'(floor_year + $urandom_range(0, 4));
            default: it.load_year = t_year'($urandom_range(1890, 2110));
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0)     it.load_month = t_month'($urandom);
        else if (pick < 4) it.load_month = 4'd2;
        else               it.load_month = t_month'($urandom_range(1, 12));
        // month ends are where the clamps live
        it.load_day    = ($urandom_range(0, 9) < 4) ? t_day'($urandom_range(28, 31))
                                                    : t_day'($urandom);
        it.load_hour   = ($urandom_range(0, 99) < 85) ? t_hour'($urandom_range(0, 23))
                                                      : t_hour'($urandom);
        it.load_minute = ($urandom_range(0, 99) < 85) ? t_minute'($urandom_range(0, 59))
                                                      : t_minute'($urandom);
        return it;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_load_clamps();
        send_op(cfadj_pkg::FUNC_FOCUS, 7);      // reset values, focus kept
        send_load(16383, 15, 31, 31, 63);       // every field saturates
        send_load(0, 0, 0, 0, 0);
        send_load(1900, 2, 30, 12, 30);         // century, not leap
        send_load(2000, 2, 31, 12, 30);         // divisible by 400
        send_load(0, 2, 31, 0, 0);              // year zero is leap
        send_load(2023, 4, 31, 0, 0);
    endtask

    task automatic test_time_wraps();
        send_op(cfadj_pkg::FUNC_FOCUS, cfadj_pkg::FOCUS_HOUR);
        send_op(cfadj_pkg::FUNC_DOWN, 0);
        send_op(cfadj_pkg::FUNC_UP, 0);
        send_op(cfadj_pkg::FUNC_FOCUS, cfadj_pkg::FOCUS_MINUTE);
        send_op(cfadj_pkg::FUNC_DOWN, 0);
        send_op(cfadj_pkg::FUNC_UP, 0);
        send_op(cfadj_pkg::FUNC_FOCUS, 5);
    endtask

    task automatic test_date_wraps();
        send_op(cfadj_pkg::FUNC_FOCUS, cfadj_pkg::FOCUS_DAY);
        send_op(cfadj_pkg::FUNC_UP, 0);         // april 30 wraps to 1
        send_op(cfadj_pkg::FUNC_DOWN, 0);
        send_load(2023, 1, 31, 8, 8);
        send_op(cfadj_pkg::FUNC_FOCUS, cfadj_pkg::FOCUS_MONTH);
        send_op(cfadj_pkg::FUNC_UP, 0);         // clamps to feb 28
        send_op(cfadj_pkg::FUNC_DOWN, 0);
        send_op(cfadj_pkg::FUNC_DOWN, 0);       // january wraps to december
        send_load(2024, 2, 29, 8, 8);
        send_op(cfadj_pkg::FUNC_FOCUS, cfadj_pkg::FOCUS_YEAR);
        send_op(cfadj_pkg::FUNC_UP, 0);         // leaves a leap year on feb 29
        send_load(9999, 6, 15, 8, 8);
        send_op(cfadj_pkg::FUNC_UP, 0);
    endtask

    task automatic test_year_floor();
        write_min_year(14'd0);
        send_load(0, 3, 1, 0, 0);
        send_op(cfadj_pkg::FUNC_DOWN, 0);       // no wrap below zero
        write_min_year(14'd16383);
        send_op(cfadj_pkg::FUNC_DOWN, 0);       // floor above max acts as max
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count, input t_year min_year);
        write_min_year(min_year);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            // hold off once per phase until every request has its result
            if (n == count / 2)
                wait_results_drained();
            push_request(random_request());
        end
        wait_results_drained();
    endtask

    initial begin
        errors             = 0;
        cycles             = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        shadow_cal         = cfadj_pkg::CAL_RESET;
        min_year_shadow    = cfadj_pkg::YEAR_RESET;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_if.valid        <= 1'b0;
        req_if.func         <= cfadj_pkg::FUNC_LOAD;
        req_if.focus_select <= '0;
        req_if.load_year    <= '0;
        req_if.load_month   <= '0;
        req_if.load_day     <= '0;
        req_if.load_hour    <= '0;
        req_if.load_minute  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_load_clamps();
        test_time_wraps();
        test_date_wraps();
        test_year_floor();
        test_random_phase(0, 0, 440, 14'd9999);
        test_random_phase(53, 0, 440, 14'd0);
        test_random_phase(0, 53, 440, 14'd16383);
        test_random_phase(25, 25, 440, t_year'($urandom_range(1900, 2100)));

        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_cal.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
